// File: rtl/sgcf_pkg.sv
// Shared types, constants and the gradient arithmetic of the Sobel contour filter.
package sgcf_pkg;

    // Line buffer geometry
    localparam int MAX_WIDTH = 4096;
    localparam int IDX_W     = $clog2(MAX_WIDTH);
    localparam int COL_W     = IDX_W + 1;
    localparam int ROW_W     = 16;
    localparam int CFG_W     = 16;

    // Register reset values
    localparam logic [12:0] WIDTH_RESET  = 13'd640;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;
    localparam logic [2:0]  MODE_RESET   = 3'd4;
    localparam logic [7:0]  THRESH_RESET = 8'd0;

    // Register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_IMAGE_WIDTH    = 2'd0;
    localparam cfg_index_t CFG_IMAGE_HEIGHT   = 2'd1;
    localparam cfg_index_t CFG_MODE           = 2'd2;
    localparam cfg_index_t CFG_MASK_THRESHOLD = 2'd3;

    // Output modes
    localparam logic [2:0] MODE_DX        = 3'd0;
    localparam logic [2:0] MODE_DY        = 3'd1;
    localparam logic [2:0] MODE_ABS_DX    = 3'd2;
    localparam logic [2:0] MODE_ABS_DY    = 3'd3;
    localparam logic [2:0] MODE_METRIC    = 3'd4;
    localparam logic [2:0] MODE_MASKED    = 3'd5;

    // Input commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] pixel;
        logic [7:0] mask_byte;
    } in_item_t;

    typedef struct packed {
        logic signed [12:0] value;
        logic               row_end;
        logic               frame_end;
    } out_item_t;

    // One line buffer entry: mask bit and pixel of the newest row, pixel of the row above
    typedef struct packed {
        logic       mask;
        logic [7:0] newer;
        logic [7:0] older;
    } line_t;

    localparam int LINE_W = $bits(line_t);

    // 3x3 neighborhood, row major: top 0..2, middle 3..5, bottom 6..8
    typedef logic [8:0][7:0] win_t;

    function automatic logic signed [10:0] ext(input logic [7:0] p);
        return $signed({3'b000, p});
    endfunction

    // Gradients, magnitudes and contour metric of one window, selected by mode
    function automatic logic signed [12:0] filter_value(input win_t w, input logic [2:0] md,
                                                         input logic mk);
        logic signed [10:0] dx;
        logic signed [10:0] dy;
        logic signed [10:0] adx;
        logic signed [10:0] ady;
        logic [9:0]         ax;
        logic [9:0]         ay;
        logic [10:0]        asum;
        logic [11:0]        metric;
        logic signed [12:0] v;
        dx = (ext(w[2]) - ext(w[0])) + ((ext(w[5]) - ext(w[3])) <<< 1)
           + (ext(w[8]) - ext(w[6]));
        dy = (ext(w[6]) - ext(w[0])) + ((ext(w[7]) - ext(w[1])) <<< 1)
           + (ext(w[8]) - ext(w[2]));
        adx = dx[10] ? -dx : dx;
        ady = dy[10] ? -dy : dy;
        ax = adx[9:0];
        ay = ady[9:0];
        asum = {1'b0, ax} + {1'b0, ay};
        metric = {asum, (ax < ay)};
        case (md)
            MODE_DX:     v = {{2{dx[10]}}, dx};
            MODE_DY:     v = {{2{dy[10]}}, dy};
            MODE_ABS_DX: v = {3'b000, ax};
            MODE_ABS_DY: v = {3'b000, ay};
            MODE_METRIC: v = {1'b0, metric};
            MODE_MASKED: v = mk ? {1'b0, metric} : 13'sd0;
            default:     v = 13'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/sobel_gradient_contour_filter_unit.sv
// Streaming 3x3 Sobel gradient and contour filter with line buffers and replicated borders.
//
//  channel | ports                                | moves
//  --------+--------------------------------------+-----------------------------------
//  input   | s_valid s_ready s_data               | pixel or drain transaction
//  output  | m_valid m_ready m_data               | up to two filter results per transaction
//  config  | cfg_valid cfg_ready cfg_index cfg_data | register write
//
//  One input transaction per cycle unless the output stalls; it passes the stage-one
//  register, then the two-entry output register. A transaction that ends a row after
//  the first yields two results, drained one per cycle; the input holds while one waits.
//  The line buffer RAM (one read and one write port) sets this single-pass rate.
//  Reset is synchronous; the line buffer is not cleared and is read only where written.
//  A stalled output holds its result and stops the stage behind it.
module sobel_gradient_contour_filter_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sgcf_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sgcf_pkg::out_item_t   m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  sgcf_pkg::cfg_index_t  cfg_index,
    input  logic [15:0]           cfg_data
);
    import sgcf_pkg::*;

    typedef struct packed {
        logic             drain;
        logic [7:0]       px;
        logic             new_mask;
        logic [IDX_W-1:0] idx;
        logic             push;
        logic             first;
        logic             emit;
        logic             last;
        logic             top_mid;
    } p1_t;

    // Configuration and control registers
    logic              rdy_reg;
    logic [12:0]       width_reg;
    logic [15:0]       height_reg;
    logic [2:0]        mode_reg;
    logic [7:0]        thresh_reg;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [COL_W-1:0]  drain_reg, drain_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              p1_valid_reg;
    p1_t               p1_reg, p1_next;
    win_t              win_reg, win_next;
    logic              mr_reg;
    logic [1:0]        p2_cnt_reg, p2_cnt_next;
    out_item_t         p2_a_reg, p2_a_next;
    out_item_t         p2_b_reg;

    logic [12:0]       eff_w;
    logic [12:0]       w_last;
    logic [ROW_W-1:0]  eff_h;
    logic              in_acc;
    logic              is_drain;
    logic [COL_W-1:0]  cnt;
    logic              active;
    logic              last;
    logic              cfg_acc;
    logic              p1_res;
    logic              p2_free;
    logic              p1_adv;
    logic              m_acc;
    logic [LINE_W-1:0] rd_raw;
    line_t             ent;
    line_t             wr_ent;
    logic [2:0][7:0]   cv;
    logic              mk;
    logic              mc1;
    win_t              win1;
    win_t              win2;
    out_item_t         o1;
    out_item_t         o2;

    // Effective frame size
    always_comb begin
        if (width_reg < 13'd2) begin
            eff_w = 13'd2;
        end else if ({1'b0, width_reg} > 14'(MAX_WIDTH)) begin
            eff_w = 13'(MAX_WIDTH);
        end else begin
            eff_w = width_reg;
        end
        w_last = eff_w - 13'd1;
        eff_h = (height_reg == '0) ? ROW_W'(1) : height_reg;
    end

    // Handshakes
    assign cfg_ready = rdy_reg;
    assign cfg_acc   = cfg_valid & cfg_ready;
    assign m_valid   = (p2_cnt_reg != 2'd0);
    assign m_data    = p2_a_reg;
    assign m_acc     = m_valid & m_ready;
    assign p1_res    = p1_reg.push & (p1_reg.emit | p1_reg.last);
    assign p2_free   = (p2_cnt_reg == 2'd0) | ((p2_cnt_reg == 2'd1) & m_ready);
    assign p1_adv    = p1_valid_reg & (~p1_res | p2_free);
    assign s_ready   = rdy_reg & (~p1_valid_reg | p1_adv);
    assign in_acc    = s_valid & s_ready;

    // Classify the incoming transaction and advance the frame counters
    always_comb begin
        is_drain = (s_data.command == CMD_DRAIN);
        cnt      = is_drain ? drain_reg : col_reg;
        active   = is_drain ? (row_reg >= eff_h) : (row_reg < eff_h);
        last     = ({1'b0, cnt} >= {{(COL_W + 1 - 13){1'b0}}, w_last});

        p1_next.drain    = is_drain;
        p1_next.px       = s_data.pixel;
        p1_next.new_mask = (s_data.mask_byte >= thresh_reg);
        p1_next.idx      = (cnt >= COL_W'(MAX_WIDTH)) ? IDX_W'(MAX_WIDTH - 1) : cnt[IDX_W-1:0];
        p1_next.push     = is_drain | (row_reg != '0);
        p1_next.first    = (cnt == '0);
        p1_next.emit     = (cnt != '0) & (is_drain | (row_reg != '0));
        p1_next.last     = last;
        p1_next.top_mid  = (row_reg == ROW_W'(1));

        col_next   = col_reg;
        drain_next = drain_reg;
        row_next   = row_reg;
        if (in_acc && active) begin
            if (is_drain) begin
                if (last) begin
                    drain_next = '0;
                    col_next   = '0;
                    row_next   = '0;
                end else begin
                    drain_next = drain_reg + COL_W'(1);
                end
            end else begin
                if (last) begin
                    col_next = '0;
                    row_next = row_reg + ROW_W'(1);
                end else begin
                    col_next = col_reg + COL_W'(1);
                end
            end
        end
    end

    // Line buffer: both previous rows and the mask bits of the newest row
    sgcf_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (p1_adv & ~p1_reg.drain),
        .wr_addr (p1_reg.idx),
        .wr_data (wr_ent),
        .rd_en   (in_acc),
        .rd_addr (p1_next.idx),
        .rd_data (rd_raw)
    );

    // Build the new window column, shift the window and compute both results
    always_comb begin
        ent   = line_t'(rd_raw);
        cv[0] = p1_reg.top_mid ? ent.newer : ent.older;
        cv[1] = ent.newer;
        cv[2] = p1_reg.drain ? ent.newer : p1_reg.px;
        mk    = ent.mask;
        mc1   = p1_reg.first ? mk : mr_reg;

        wr_ent.mask  = p1_reg.new_mask;
        wr_ent.newer = p1_reg.px;
        wr_ent.older = ent.newer;

        for (int r = 0; r < 3; r++) begin
            win1[r*3]     = p1_reg.first ? cv[r] : win_reg[r*3+1];
            win1[r*3+1]   = p1_reg.first ? cv[r] : win_reg[r*3+2];
            win1[r*3+2]   = cv[r];
            win2[r*3]     = win1[r*3+1];
            win2[r*3+1]   = win1[r*3+2];
            win2[r*3+2]   = win1[r*3+2];
        end
        win_next = p1_reg.last ? win2 : win1;

        o1.value     = filter_value(win1, mode_reg, mc1);
        o1.row_end   = 1'b0;
        o1.frame_end = 1'b0;
        o2.value     = filter_value(win2, mode_reg, mk);
        o2.row_end   = 1'b1;
        o2.frame_end = p1_reg.drain;
    end

    // Output register pair: load a finished transaction's results, else drain one
    always_comb begin
        p2_cnt_next = p2_cnt_reg;
        p2_a_next   = p2_a_reg;
        if (p1_adv && p1_res) begin
            p2_cnt_next = {1'b0, p1_reg.emit} + {1'b0, p1_reg.last};
            p2_a_next   = p1_reg.emit ? o1 : o2;
        end else if (m_acc) begin
            if (p2_cnt_reg == 2'd2) begin
                p2_cnt_next = 2'd1;
                p2_a_next   = p2_b_reg;
            end else begin
                p2_cnt_next = 2'd0;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rdy_reg      <= 1'b0;
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            mode_reg     <= MODE_RESET;
            thresh_reg   <= THRESH_RESET;
            col_reg      <= '0;
            drain_reg    <= '0;
            row_reg      <= '0;
            p1_valid_reg <= 1'b0;
            win_reg      <= '0;
            mr_reg       <= 1'b0;
            p2_cnt_reg   <= 2'd0;
        end else begin
            rdy_reg    <= 1'b1;
            col_reg    <= col_next;
            drain_reg  <= drain_next;
            row_reg    <= row_next;
            p2_cnt_reg <= p2_cnt_next;
            if (cfg_acc) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:    width_reg  <= cfg_data[12:0];
                    CFG_IMAGE_HEIGHT:   height_reg <= cfg_data;
                    CFG_MODE:           mode_reg   <= cfg_data[2:0];
                    CFG_MASK_THRESHOLD: thresh_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                p1_valid_reg <= active;
            end else if (p1_adv) begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_adv && p1_reg.push) begin
                win_reg <= win_next;
                mr_reg  <= mk;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            p1_reg <= p1_next;
        end
        p2_a_reg <= p2_a_next;
        if (p1_adv && p1_res) begin
            p2_b_reg <= o2;
        end
    end

endmodule

// File: rtl/sgcf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sgcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/sgcf_checker.sv
// Port-level assertions for the Sobel contour filter and their binding to the top level.
module sgcf_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input sgcf_pkg::out_item_t m_data
);
    import sgcf_pkg::*;

    // Hold a stalled result transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result transaction changed while stalled");

    // Frame end only on the last result of a row
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.frame_end || m_data.row_end))
        else $error("frame end without row end");

    // A fresh result traces back to an accepted input transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result appeared without a matching input transaction");

    // Drop all results during reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind sobel_gradient_contour_filter_unit sgcf_checker u_sgcf_checker (.*);

// File: tb/sv/sobel_gradient_contour_filter_unit_tb.sv
// Self-checking stream testbench for the Sobel gradient contour filter unit.
`timescale 1ns / 100ps

module sobel_gradient_contour_filter_unit_tb;
    import sgcf_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int QUIET_CYCLES = 8;
    // Modes without a name in the package; both yield zero
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = CFG_IMAGE_WIDTH;
    logic [15:0] cfg_data = '0;

    logic burst_mode = 1'b0;
    int   mismatches = 0;
    int   stall_cycles = 0;

    // Predicted filter state
    logic [12:0] reg_width = WIDTH_RESET;
    logic [15:0] reg_height = HEIGHT_RESET;
    logic [2:0]  reg_mode = MODE_RESET;
    logic [7:0]  reg_thresh = THRESH_RESET;
    logic [7:0]  line_older [MAX_WIDTH];
    logic [7:0]  line_newer [MAX_WIDTH];
    logic        line_mask [MAX_WIDTH];
    logic [7:0]  nbhd [9];
    logic        mask_mid;
    logic        mask_next;
    int unsigned col_cnt;
    int unsigned row_cnt;
    int unsigned drain_cnt;

    out_item_t expected_results [$];

    sobel_gradient_contour_filter_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned width_used();
        if (reg_width < 2) return 2;
        if (reg_width > MAX_WIDTH) return MAX_WIDTH;
        return reg_width;
    endfunction

    function automatic int unsigned height_used();
        return (reg_height == 0) ? 1 : reg_height;
    endfunction

    // Shift a new right column into the 3x3 neighborhood; a first column fills it
    function automatic void shift_in_column(input logic [7:0] top_px, input logic [7:0] mid_px,
                                            input logic [7:0] bot_px, input logic mk,
                                            input logic first);
        logic [7:0] col [3];
        col = '{top_px, mid_px, bot_px};
        for (int r = 0; r < 3; r++) begin
            if (first) begin
                nbhd[r * 3] = col[r];
                nbhd[r * 3 + 1] = col[r];
            end else begin
                nbhd[r * 3] = nbhd[r * 3 + 1];
                nbhd[r * 3 + 1] = nbhd[r * 3 + 2];
            end
            nbhd[r * 3 + 2] = col[r];
        end
        mask_mid = first ? mk : mask_next;
        mask_next = mk;
    endfunction

    // Gradients and contour metric of the current neighborhood, selected by mode
    function automatic logic signed [12:0] sobel_value(input logic mk);
        int dx, dy, ax, ay, metric, v;
        dx = (int'(nbhd[2]) - int'(nbhd[0])) + 2 * (int'(nbhd[5]) - int'(nbhd[3]))
           + (int'(nbhd[8]) - int'(nbhd[6]));
        dy = (int'(nbhd[6]) - int'(nbhd[0])) + 2 * (int'(nbhd[7]) - int'(nbhd[1]))
           + (int'(nbhd[8]) - int'(nbhd[2]));
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        metric = 2 * (ax + ay) + ((ax < ay) ? 1 : 0);
        case (reg_mode)
            MODE_DX:     v = dx;
            MODE_DY:     v = dy;
            MODE_ABS_DX: v = ax;
            MODE_ABS_DY: v = ay;
            MODE_METRIC: v = metric;
            MODE_MASKED: v = mk ? metric : 0;
            default:     v = 0;
        endcase
        return v[12:0];
    endfunction

    function automatic void queue_result(input logic mk, input logic re, input logic fe);
        out_item_t r;
        r.value = sobel_value(mk);
        r.row_end = re;
        r.frame_end = fe;
        expected_results.push_back(r);
    endfunction

    // Advance the output position one column; the last column closes the row
    function automatic void step_column(input int unsigned col, input logic [7:0] top_px,
                                        input logic [7:0] mid_px, input logic [7:0] bot_px,
                                        input logic mk, input logic drain);
        logic last;
        last = (col >= width_used() - 1);
        shift_in_column(top_px, mid_px, bot_px, mk, col == 0);
        if (col >= 1) queue_result(mask_mid, 1'b0, 1'b0);
        if (last) begin
            shift_in_column(nbhd[2], nbhd[5], nbhd[8], mask_next, 1'b0);
            queue_result(mask_mid, 1'b1, drain);
        end
    endfunction

    // Work out the results caused by one accepted transaction
    function automatic void predict_filter_outputs(input in_item_t it);
        int unsigned w, h, c;
        logic [7:0] top_px, mid_px;
        logic new_mask;
        w = width_used();
        h = height_used();
        if (it.command == CMD_PIXEL) begin
            if (row_cnt >= h) return;
            c = col_cnt;
            new_mask = (it.mask_byte >= reg_thresh);
            if (row_cnt >= 1) begin
                top_px = (row_cnt == 1) ? line_newer[c] : line_older[c];
                step_column(c, top_px, line_newer[c], it.pixel, line_mask[c], 1'b0);
            end
            line_older[c] = line_newer[c];
            line_newer[c] = it.pixel;
            line_mask[c] = new_mask;
            if (c >= w - 1) begin
                col_cnt = 0;
                row_cnt = (row_cnt + 1) & 16'hFFFF;
            end else begin
                col_cnt = c + 1;
            end
        end else begin
            if (row_cnt < h) return;
            c = drain_cnt;
            mid_px = line_newer[c];
            top_px = (row_cnt >= 2) ? line_older[c] : mid_px;
            step_column(c, top_px, mid_px, mid_px, line_mask[c], 1'b1);
            if (c >= w - 1) begin
                drain_cnt = 0;
                col_cnt = 0;
                row_cnt = 0;
            end else begin
                drain_cnt = c + 1;
            end
        end
    endfunction

    function automatic logic [7:0] random_pixel();
        if ($urandom_range(3) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
        return 8'($urandom);
    endfunction

    // Send one transaction, idling at random first; valid stays high on return
    task automatic send_item(input in_item_t it);
        while (!burst_mode && $urandom_range(99) < 20) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_filter_outputs(it);
    endtask

    task automatic send_pixel(input logic [7:0] px, input logic [7:0] mb);
        send_item('{command: CMD_PIXEL, pixel: px, mask_byte: mb});
    endtask

    task automatic send_drain();
        send_item('{command: CMD_DRAIN, pixel: 8'($urandom), mask_byte: 8'($urandom)});
    endtask

    // Hold the input until every expected result is out and the pipeline is empty
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    // Write one register with the pipeline empty
    task automatic write_reg(input cfg_index_t idx, input logic [15:0] d);
        wait_quiet();
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_IMAGE_WIDTH:    reg_width = d[12:0];
            CFG_IMAGE_HEIGHT:   reg_height = d;
            CFG_MODE:           reg_mode = d[2:0];
            CFG_MASK_THRESHOLD: reg_thresh = d[7:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Power-up geometry: one full row, then close the second row and the frame early
    task automatic test_reset_config();
        for (int i = 0; i < 642; i++) begin
            // a long run with no idling on either side
            burst_mode <= (i >= 200 && i < 450);
            send_pixel(random_pixel(), 8'($urandom));
        end
        burst_mode <= 1'b0;
        wait_quiet();
        // the row being filled ends at the new, smaller width
        write_reg(CFG_IMAGE_WIDTH, 16'd2);
        send_pixel(random_pixel(), 8'($urandom));
        write_reg(CFG_IMAGE_HEIGHT, 16'd2);
        repeat (2) send_drain();
    endtask

    // Narrowest rows, every mode in turn, ignored drain and pixel transactions
    task automatic test_mode_sweep();
        logic [7:0] mask_vals [4];
        logic [2:0] sweep_modes [8];
        mask_vals = '{8'd0, 8'd127, 8'd128, 8'd255};
        sweep_modes = '{MODE_DX, MODE_DY, MODE_ABS_DX, MODE_ABS_DY, MODE_METRIC,
                        MODE_MASKED, MODE_RSVD6, MODE_RSVD7};
        // a width below two is used as two
        write_reg(CFG_IMAGE_WIDTH, 16'd1);
        write_reg(CFG_IMAGE_HEIGHT, 16'd8);
        write_reg(CFG_MASK_THRESHOLD, 16'd128);
        send_drain();
        for (int r = 0; r < 8; r++) begin
            if (r >= 1) begin
                wait_quiet();
                write_reg(CFG_MODE, {13'd0, sweep_modes[r - 1]});
            end
            send_pixel(r[0] ? 8'hFF : 8'h00, mask_vals[(2 * r) % 4]);
            send_pixel(r[1] ? 8'h00 : 8'hFF, mask_vals[(2 * r + 1) % 4]);
        end
        // frame complete: this pixel is dropped
        send_pixel(8'hFF, 8'hFF);
        wait_quiet();
        write_reg(CFG_MODE, {13'd0, sweep_modes[7]});
        repeat (2) send_drain();
    endtask

    // Shrink the width in the middle of a row: the row ends at the new limit
    task automatic test_width_shrink();
        write_reg(CFG_IMAGE_WIDTH, 16'd8);
        write_reg(CFG_IMAGE_HEIGHT, 16'd4);
        write_reg(CFG_MODE, {13'd0, MODE_METRIC});
        repeat (13) send_pixel(random_pixel(), 8'($urandom));
        wait_quiet();
        write_reg(CFG_IMAGE_WIDTH, 16'd3);
        repeat (7) send_pixel(random_pixel(), 8'($urandom));
        repeat (3) send_drain();
    endtask

    // Tallest frame setting, ended early by lowering the height below the row count
    task automatic test_tallest_frame();
        write_reg(CFG_IMAGE_WIDTH, 16'd4);
        write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
        write_reg(CFG_MODE, {13'd0, MODE_DX});
        repeat (12) send_pixel(random_pixel(), 8'($urandom));
        wait_quiet();
        write_reg(CFG_IMAGE_HEIGHT, 16'd2);
        send_pixel(random_pixel(), 8'($urandom));
        repeat (4) send_drain();
    endtask

    // Whole frames of random size and content, with stray transactions mixed in
    task automatic test_random_frames();
        int unsigned sent, w, h;
        logic [12:0] new_width;
        logic [7:0] new_thresh;
        sent = 0;
        while (sent < 100) begin
            if ($urandom_range(1) == 0) begin
                wait_quiet();
                new_width = ($urandom_range(9) == 0) ? 13'($urandom_range(1))
                                                      : 13'($urandom_range(2, 16));
                case ($urandom_range(3))
                    0: new_thresh = 8'd0;
                    1: new_thresh = 8'd255;
                    default: new_thresh = 8'($urandom);
                endcase
                if ($urandom_range(3) != 0)
                    write_reg(CFG_IMAGE_WIDTH, {3'($urandom), new_width});
                if ($urandom_range(3) != 0)
                    write_reg(CFG_IMAGE_HEIGHT, ($urandom_range(7) == 0) ? 16'd0
                                                : 16'($urandom_range(1, 5)));
                if ($urandom_range(3) != 0)
                    write_reg(CFG_MODE, {13'($urandom), 3'($urandom)});
                if ($urandom_range(3) != 0)
                    write_reg(CFG_MASK_THRESHOLD, {8'($urandom), new_thresh});
            end
            w = width_used();
            h = height_used();
            for (int r = 0; r < h; r++) begin
                // occasionally switch mode between rows
                if (r > 0 && $urandom_range(19) == 0) begin
                    wait_quiet();
                    write_reg(CFG_MODE, {13'($urandom), 3'($urandom)});
                end
                for (int c = 0; c < w; c++) begin
                    if ($urandom_range(19) == 0) send_drain();
                    send_pixel(random_pixel(), 8'($urandom));
                end
            end
            for (int c = 0; c < w; c++) begin
                if ($urandom_range(19) == 0) send_pixel(random_pixel(), 8'($urandom));
                send_drain();
            end
            sent += (h + 1) * w;
        end
    endtask

    // Result channel: compare each transaction with the oldest expectation
    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %0d row_end %0b frame_end %0b",
                             m_data.value, m_data.row_end, m_data.frame_end);
            end else begin
                want = expected_results.pop_front();
                if (m_data.value !== want.value || m_data.row_end !== want.row_end
                    || m_data.frame_end !== want.frame_end) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: value %0d/%0d row_end %0b/%0b frame_end %0b/%0b",
                                 want.value, m_data.value, want.row_end, m_data.row_end,
                                 want.frame_end, m_data.frame_end);
                end
            end
        end
        m_ready <= burst_mode || ($urandom_range(99) >= 20);
    end

    // Watchdog: end the run when no channel moves a transaction for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("sobel_gradient_contour_filter_unit test failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
            line_older[i] = '0;
            line_newer[i] = '0;
            line_mask[i] = 1'b0;
        end
        for (int i = 0; i < 9; i++) nbhd[i] = '0;
        mask_mid = 1'b0;
        mask_next = 1'b0;
        col_cnt = 0;
        row_cnt = 0;
        drain_cnt = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_config();
        test_mode_sweep();
        test_width_shrink();
        test_tallest_frame();
        test_random_frames();
        wait_quiet();
        repeat (16) @(posedge aclk);
        if (mismatches == 0)
            $display("sobel_gradient_contour_filter_unit test passed");
        else
            $display("sobel_gradient_contour_filter_unit test failed");
        $finish;
    end

endmodule
